// File: hw/rtl/ess_pkg.sv
`timescale 1ns / 1ps
// Shared constants, event and direction codes, and FSM type for the elevator stop scheduler.
// No dependencies.
package ess_pkg;

    // Number of served floors (valid range 2..31).
    localparam int FLOORS      = 16;

    localparam int FLOOR_W     = 5;     // floor field width
    localparam int DIR_W       = 2;     // direction field width
    localparam int MODE_W      = 2;     // event kind width
    localparam int IN_DATA_W   = 8;     // floor padded to bytes
    localparam int IN_USER_W   = 8;     // event kind padded to bytes
    localparam int OUT_DATA_W  = 8;     // stop floor + direction padded to bytes
    localparam int OUT_PAD_W   = OUT_DATA_W - FLOOR_W - DIR_W;

    // Request bitmap index and scan counter widths.
    localparam int IDX_W       = $clog2(FLOORS);
    localparam int FLOOR_IDX_W = $clog2(FLOORS + 1);
    localparam int SCAN_W      = (FLOOR_IDX_W > FLOOR_W) ? FLOOR_IDX_W : FLOOR_W;

    // Event kinds.
    localparam logic [MODE_W-1:0] MODE_CALL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

    // Travel directions.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TARGET = 4'b0010,
        ST_ROUTE  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

endpackage

// File: hw/rtl/elevator_stop_scheduler.sv
`timescale 1ns / 1ps
// Elevator stop scheduler: request bitmap, floor walker and stream ports.
// Depends on ess_pkg.

// One request is handled at a time. A floor-passed event, or any ignored event,
// needs no work past the idle state. A call goes through a route walk and then
// the result state. An arrival goes through a route walk and the result state,
// with a far-target walk first when the car reaches its target; it skips the
// result state when nothing is left and the car goes idle.
// Each walk steps a single floor counter through the request bitmap, one floor
// per cycle. An upward route walk may start at floor zero, which reads unmarked,
// and a downward route walk from above the top starts at the top floor. A
// finished result sits in the output register, so the next request is taken
// while the downstream side still holds off; a further result waits for it.
// There is no clearing pass: the bitmap lives in flops and reset clears it.
module elevator_stop_scheduler
    import ess_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // [4:0] floor_number, [7:5] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] mode, [7:2] zero
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] stop_floor, [6:5] travel_direction, [7] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    localparam logic [SCAN_W-1:0] FLOORS_S = SCAN_W'(FLOORS);
    localparam logic [SCAN_W-1:0] ONE_S    = SCAN_W'(1);

    // Architectural state
    state_t               state_reg, state_next;
    logic [FLOORS-1:0]    req_reg, req_next;
    logic [FLOOR_W-1:0]   present_reg, present_next;
    logic [FLOOR_W-1:0]   far_reg, far_next;
    logic [DIR_W-1:0]     heading_reg, heading_next;
    logic                 busy_reg, busy_next;

    // Walker and per-request context
    logic [SCAN_W-1:0]    cnt_reg, cnt_next;
    logic                 scan_up_reg, scan_up_next;
    logic                 is_call_reg, is_call_next;
    logic [FLOOR_W-1:0]   call_floor_reg, call_floor_next;
    logic [FLOOR_W-1:0]   stop_reg, stop_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [FLOOR_W-1:0]   out_stop_reg, out_stop_next;
    logic [DIR_W-1:0]     out_dir_reg, out_dir_next;

    logic [MODE_W-1:0]    in_mode;
    logic [FLOOR_W-1:0]   in_floor;
    logic [SCAN_W-1:0]    in_floor_s;
    logic [SCAN_W-1:0]    in_idx_s;
    logic                 in_range;
    logic                 accept;
    logic [SCAN_W-1:0]    scan_idx_s;
    logic                 scan_hit;
    logic                 scan_end;
    logic [FLOOR_W-1:0]   call_far;
    logic [FLOOR_W-1:0]   hit_far;

    // First floor of a route walk from the given floor.
    function automatic logic [SCAN_W-1:0] route_start(input logic up,
                                                      input logic [FLOOR_W-1:0] pres);
        logic [SCAN_W-1:0] p;
        p = SCAN_W'(pres);
        if (!up && (p > FLOORS_S))
            return FLOORS_S;
        return p;
    endfunction

    assign in_mode    = s_axis_tuser[MODE_W-1:0];
    assign in_floor   = s_axis_tdata[FLOOR_W-1:0];
    assign in_floor_s = SCAN_W'(in_floor);
    assign in_idx_s   = in_floor_s - ONE_S;
    assign in_range   = (in_floor_s >= ONE_S) && (in_floor_s <= FLOORS_S);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Bitmap probe at the walker position; out-of-range floors read unmarked.
    assign scan_idx_s = cnt_reg - ONE_S;
    assign scan_hit   = (cnt_reg >= ONE_S) && (cnt_reg <= FLOORS_S) &&
                        req_reg[scan_idx_s[IDX_W-1:0]];
    assign scan_end   = scan_up_reg ? (cnt_reg >= FLOORS_S) : (cnt_reg <= ONE_S);

    // Target after a call: widen along heading, or take the call with no target.
    assign call_far = (((heading_reg == DIR_UP) && (in_floor > far_reg)) ||
                       ((heading_reg == DIR_DOWN) && (in_floor < far_reg)) ||
                       (far_reg == '0)) ? in_floor : far_reg;
    assign hit_far  = scan_hit ? cnt_reg[FLOOR_W-1:0] : far_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        present_next    = present_reg;
        far_next        = far_reg;
        heading_next    = heading_reg;
        busy_next       = busy_reg;
        cnt_next        = cnt_reg;
        scan_up_next    = scan_up_reg;
        is_call_next    = is_call_reg;
        call_floor_next = call_floor_reg;
        stop_next       = stop_reg;
        out_valid_next  = out_valid_reg;
        out_stop_next   = out_stop_reg;
        out_dir_next    = out_dir_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_CALL:
                        begin
                            if (in_range)
                            begin
                                busy_next                   = 1'b1;
                                req_next[in_idx_s[IDX_W-1:0]] = 1'b1;
                                far_next                    = call_far;
                                is_call_next                = 1'b1;
                                call_floor_next             = in_floor;
                                scan_up_next                = call_far > present_reg;
                                cnt_next   = route_start(call_far > present_reg, present_reg);
                                state_next = ST_ROUTE;
                            end
                        end
                        MODE_ARRIVE:
                        begin
                            if (busy_reg)
                            begin
                                present_next = in_floor;
                                is_call_next = 1'b0;
                                if (in_range)
                                    req_next[in_idx_s[IDX_W-1:0]] = 1'b0;
                                if (in_floor == far_reg)
                                begin
                                    // Target reached: look for a new far target.
                                    far_next     = '0;
                                    scan_up_next = (heading_reg != DIR_UP);
                                    cnt_next     = (heading_reg == DIR_UP) ? FLOORS_S : ONE_S;
                                    state_next   = ST_TARGET;
                                end
                                else
                                begin
                                    scan_up_next = far_reg > in_floor;
                                    cnt_next     = route_start(far_reg > in_floor, in_floor);
                                    state_next   = ST_ROUTE;
                                end
                            end
                        end
                        MODE_PASS:
                        begin
                            present_next = in_floor;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TARGET:
            begin
                if (scan_hit || scan_end)
                begin
                    far_next     = hit_far;
                    scan_up_next = hit_far > present_reg;
                    cnt_next     = route_start(hit_far > present_reg, present_reg);
                    state_next   = ST_ROUTE;
                end
                else
                begin
                    cnt_next = scan_up_reg ? cnt_reg + ONE_S : cnt_reg - ONE_S;
                end
            end
            ST_ROUTE:
            begin
                if (scan_hit || (scan_end && is_call_reg))
                begin
                    stop_next    = scan_hit ? cnt_reg[FLOOR_W-1:0] : call_floor_reg;
                    heading_next = (far_reg > present_reg) ? DIR_UP : DIR_DOWN;
                    state_next   = ST_RESULT;
                end
                else if (scan_end)
                begin
                    // Nothing left on the route: go idle, keep heading.
                    busy_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = scan_up_reg ? cnt_reg + ONE_S : cnt_reg - ONE_S;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stop_next  = stop_reg;
                    out_dir_next   = heading_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            present_reg   <= FLOOR_W'(1);
            far_reg       <= '0;
            heading_reg   <= DIR_NONE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            present_reg   <= present_next;
            far_reg       <= far_next;
            heading_reg   <= heading_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        scan_up_reg    <= scan_up_next;
        is_call_reg    <= is_call_next;
        call_floor_reg <= call_floor_next;
        stop_reg       <= stop_next;
        out_stop_reg   <= out_stop_next;
        out_dir_reg    <= out_dir_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_dir_reg, out_stop_reg};

    // A posted stop always carries a real direction.
    a_dir_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_dir_reg == DIR_UP || out_dir_reg == DIR_DOWN))
        else $error("result with no travel direction");

    // A posted stop is a served floor.
    a_stop_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (SCAN_W'(out_stop_reg) >= ONE_S &&
                           SCAN_W'(out_stop_reg) <= FLOORS_S))
        else $error("stop floor out of range");

    // A new result only comes while the car is busy.
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> busy_reg)
        else $error("result while idle");

    // A floor-passed event leaves the input ready again in the next cycle.
    a_pass_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_PASS) |=> s_axis_tready)
        else $error("floor-passed event did not finish in one cycle");

endmodule
